// ----- sv/line_rasterizer_defines.svh -----
// assertion macros shared by the line rasterizer checker
// no dependencies; included by file name where assertions are written
`ifndef LINE_RASTERIZER_DEFINES_SVH
`define LINE_RASTERIZER_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define LRAST_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define LRAST_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/lrast_pkg.sv -----
// line rasterizer package: widths, request codes and word/state structs
// no dependencies; used by every other file of the block except the assertion macro header
package lrast_pkg;

   localparam int unsigned COORD_BITS = 12;
   // error spans about +/- 2 * (2^COORD_BITS - 1), plus headroom
   localparam int unsigned ERR_BITS = COORD_BITS + 3;

   localparam logic REQ_START   = 1'b0;
   localparam logic REQ_ADVANCE = 1'b1;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic [COORD_BITS-1:0]        len_type;
   typedef logic signed [ERR_BITS-1:0]   err_type;

   typedef struct packed {
      logic      req_type;
      coord_type start_x;
      coord_type start_y;
      coord_type end_x;
      coord_type end_y;
   } req_word_type;

   typedef struct packed {
      logic      active;
      coord_type cur_x;
      coord_type cur_y;
      len_type   steps_left;
      err_type   error_term;
      len_type   major_len;
      len_type   minor_len;
      logic      major_is_x;
      logic      step_x_neg;
      logic      step_y_neg;
   } line_state_type;

   typedef struct packed {
      coord_type pixel_x;
      coord_type pixel_y;
      logic      last_pixel;
   } pixel_word_type;

endpackage

// ----- sv/lrast_if.sv -----
// valid/ready channel interfaces for request and pixel words
// depends on lrast_pkg
interface lrast_req_if;
   logic                  valid;
   logic                  ready;
   logic                  req_type;
   lrast_pkg::coord_type  start_x;
   lrast_pkg::coord_type  start_y;
   lrast_pkg::coord_type  end_x;
   lrast_pkg::coord_type  end_y;

   modport source (output valid, req_type, start_x, start_y, end_x, end_y, input ready);
   modport sink   (input valid, req_type, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lrast_rsp_if;
   logic                  valid;
   logic                  ready;
   lrast_pkg::coord_type  pixel_x;
   lrast_pkg::coord_type  pixel_y;
   logic                  last_pixel;

   modport source (output valid, pixel_x, pixel_y, last_pixel, input ready);
   modport sink   (input valid, pixel_x, pixel_y, last_pixel, output ready);
endinterface

// ----- sv/lrast_setup.sv -----
// line setup: deltas, major axis, initial error and first pixel of a new line
// depends on lrast_pkg
module lrast_setup (
   input  lrast_pkg::req_word_type   word,
   output lrast_pkg::line_state_type line_state,
   output lrast_pkg::pixel_word_type pixel
);

   logic signed [lrast_pkg::COORD_BITS:0] diff_x;
   logic signed [lrast_pkg::COORD_BITS:0] diff_y;
   logic signed [lrast_pkg::COORD_BITS:0] neg_x;
   logic signed [lrast_pkg::COORD_BITS:0] neg_y;
   lrast_pkg::len_type                    mag_x;
   lrast_pkg::len_type                    mag_y;
   lrast_pkg::len_type                    major;
   lrast_pkg::len_type                    minor;
   logic                                  x_major;

   always_comb begin
      diff_x = {word.end_x[lrast_pkg::COORD_BITS-1], word.end_x}
             - {word.start_x[lrast_pkg::COORD_BITS-1], word.start_x};
      diff_y = {word.end_y[lrast_pkg::COORD_BITS-1], word.end_y}
             - {word.start_y[lrast_pkg::COORD_BITS-1], word.start_y};
      neg_x  = -diff_x;
      neg_y  = -diff_y;
      // magnitude always fits the coordinate width as unsigned
      mag_x  = diff_x[lrast_pkg::COORD_BITS] ? neg_x[lrast_pkg::COORD_BITS-1:0]
                                             : diff_x[lrast_pkg::COORD_BITS-1:0];
      mag_y  = diff_y[lrast_pkg::COORD_BITS] ? neg_y[lrast_pkg::COORD_BITS-1:0]
                                             : diff_y[lrast_pkg::COORD_BITS-1:0];
      x_major = (mag_x >= mag_y);
      major   = x_major ? mag_x : mag_y;
      minor   = x_major ? mag_y : mag_x;

      line_state.active     = (major != '0);
      line_state.cur_x      = word.start_x;
      line_state.cur_y      = word.start_y;
      line_state.steps_left = major;
      line_state.error_term = lrast_pkg::ERR_BITS'({minor, 1'b0})
                            - lrast_pkg::ERR_BITS'(major);
      line_state.major_len  = major;
      line_state.minor_len  = minor;
      line_state.major_is_x = x_major;
      line_state.step_x_neg = diff_x[lrast_pkg::COORD_BITS];
      line_state.step_y_neg = diff_y[lrast_pkg::COORD_BITS];

      pixel.pixel_x    = word.start_x;
      pixel.pixel_y    = word.start_y;
      pixel.last_pixel = (major == '0);
   end

endmodule

// ----- sv/lrast_advance.sv -----
// one bresenham step: error update, coordinate moves, step count
// depends on lrast_pkg
module lrast_advance (
   input  lrast_pkg::line_state_type cur,
   output lrast_pkg::line_state_type next,
   output lrast_pkg::pixel_word_type pixel
);

   logic                          step_minor;
   logic                          move_x;
   logic                          move_y;
   logic [lrast_pkg::ERR_BITS-1:0] twice_minor;
   logic [lrast_pkg::ERR_BITS-1:0] twice_major;
   logic [lrast_pkg::ERR_BITS-1:0] err_cur;
   lrast_pkg::coord_type           x_next;
   lrast_pkg::coord_type           y_next;
   lrast_pkg::len_type             steps_next;

   always_comb begin
      step_minor  = !cur.error_term[lrast_pkg::ERR_BITS-1];
      move_x      = cur.major_is_x || step_minor;
      move_y      = !cur.major_is_x || step_minor;
      twice_minor = lrast_pkg::ERR_BITS'({cur.minor_len, 1'b0});
      twice_major = lrast_pkg::ERR_BITS'({cur.major_len, 1'b0});
      err_cur     = cur.error_term;

      x_next = cur.cur_x;
      if (move_x) begin
         x_next = cur.step_x_neg ? cur.cur_x - lrast_pkg::coord_type'(1)
                                 : cur.cur_x + lrast_pkg::coord_type'(1);
      end
      y_next = cur.cur_y;
      if (move_y) begin
         y_next = cur.step_y_neg ? cur.cur_y - lrast_pkg::coord_type'(1)
                                 : cur.cur_y + lrast_pkg::coord_type'(1);
      end
      steps_next = cur.steps_left - lrast_pkg::len_type'(1);

      next            = cur;
      next.cur_x      = x_next;
      next.cur_y      = y_next;
      next.steps_left = steps_next;
      next.active     = (steps_next != '0);
      next.error_term = step_minor ? err_cur + twice_minor - twice_major
                                   : err_cur + twice_minor;

      pixel.pixel_x    = x_next;
      pixel.pixel_y    = y_next;
      pixel.last_pixel = (steps_next == '0);
   end

endmodule

// ----- sv/line_rasterizer.sv -----
// line_rasterizer top: input stage, line state and pixel output register
// depends on lrast_pkg, lrast_if, lrast_setup and lrast_advance
//
//   channel   direction  payload                                      handshake
//   req_ch    in         req_type, start_x, start_y, end_x, end_y     valid/ready
//   rsp_ch    out        pixel_x, pixel_y, last_pixel                 valid/ready
//
// one request word per clock, one pixel word per clock when the output is drained
// a taken word is registered in the input stage and then in the output register before its pixel shows
// the rate is set by the single setup/step pass between input stage and output register
// a full output register stalls the input stage; req ready follows rsp ready in the same cycle
// an advance with no active line is consumed and gives no pixel word
// synchronous reset empties both stages and clears the line state
module line_rasterizer (
   input  logic              clock,
   input  logic              reset,
   lrast_req_if.sink         req_ch,
   lrast_rsp_if.source       rsp_ch
);

   // input stage
   logic                      s1_valid_ff;
   logic                      s1_valid_in;
   lrast_pkg::req_word_type   s1_word_ff;
   lrast_pkg::req_word_type   s1_word_in;

   // line state
   lrast_pkg::line_state_type line_ff;
   lrast_pkg::line_state_type line_in;

   // output register
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   lrast_pkg::pixel_word_type rsp_word_ff;
   lrast_pkg::pixel_word_type rsp_word_in;

   lrast_pkg::line_state_type setup_state;
   lrast_pkg::pixel_word_type setup_pixel;
   lrast_pkg::line_state_type step_state;
   lrast_pkg::pixel_word_type step_pixel;

   logic                      out_free;
   logic                      s1_go;
   logic                      take_in;
   logic                      is_start;
   logic                      emit;

   lrast_setup u_setup (
      .word       (s1_word_ff),
      .line_state (setup_state),
      .pixel      (setup_pixel)
   );

   lrast_advance u_advance (
      .cur   (line_ff),
      .next  (step_state),
      .pixel (step_pixel)
   );

   always_comb begin
      // output register can take a new word when empty or being drained
      out_free = !rsp_valid_ff || rsp_ch.ready;
      s1_go    = s1_valid_ff && out_free;
      req_ch.ready = !reset && (!s1_valid_ff || s1_go);
      take_in  = req_ch.valid && req_ch.ready;

      is_start = (s1_word_ff.req_type == lrast_pkg::REQ_START);
      // advance only produces a pixel while a line is active
      emit     = s1_go && (is_start || line_ff.active);

      s1_word_in.req_type = req_ch.req_type;
      s1_word_in.start_x  = req_ch.start_x;
      s1_word_in.start_y  = req_ch.start_y;
      s1_word_in.end_x    = req_ch.end_x;
      s1_word_in.end_y    = req_ch.end_y;

      s1_valid_in = take_in || (s1_valid_ff && !s1_go);

      line_in     = line_ff;
      rsp_word_in = rsp_word_ff;
      if (emit) begin
         line_in     = is_start ? setup_state : step_state;
         rsp_word_in = is_start ? setup_pixel : step_pixel;
      end

      if (s1_go) begin
         rsp_valid_in = emit;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      rsp_ch.valid      = rsp_valid_ff;
      rsp_ch.pixel_x    = rsp_word_ff.pixel_x;
      rsp_ch.pixel_y    = rsp_word_ff.pixel_y;
      rsp_ch.last_pixel = rsp_word_ff.last_pixel;
   end

   // control state and line registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         line_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         line_ff      <= line_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (take_in) begin
         s1_word_ff <= s1_word_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

endmodule

// ----- sv/lrast_chk.sv -----
// port-level checker for line_rasterizer, bound to the top level
// depends on lrast_pkg, lrast_if and line_rasterizer_defines.svh
`include "line_rasterizer_defines.svh"

module lrast_chk (
   input  logic         clock,
   input  logic         reset,
   lrast_req_if.sink    req_ch,
   lrast_rsp_if.source  rsp_ch
);

   // stalled pixel word holds
   `LRAST_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_ch.valid && !rsp_ch.ready, rsp_ch.valid && $stable(rsp_ch.pixel_x) && $stable(rsp_ch.pixel_y) && $stable(rsp_ch.last_pixel), "pixel word changed while stalled")

   // a fresh pixel word always follows a taken request word that passed the input stage and the output register
   `LRAST_ASSERT_IMPL(a_rsp_cause, clock, reset, $rose(rsp_ch.valid), $past(req_ch.valid && req_ch.ready, 2), "pixel word without a request")

   // a start with a free output passes the input stage and gives its start point from the output register
   `LRAST_ASSERT_NEXT(a_start_pixel, clock, reset, (req_ch.valid && req_ch.ready && (req_ch.req_type == lrast_pkg::REQ_START)) ##1 rsp_ch.ready, rsp_ch.valid && (rsp_ch.pixel_x == $past(req_ch.start_x, 2)) && (rsp_ch.pixel_y == $past(req_ch.start_y, 2)), "start pixel missing or wrong")

   // a single-point line is flagged last on its only pixel
   `LRAST_ASSERT_NEXT(a_point_last, clock, reset, (req_ch.valid && req_ch.ready && (req_ch.req_type == lrast_pkg::REQ_START) && (req_ch.start_x == req_ch.end_x) && (req_ch.start_y == req_ch.end_y)) ##1 rsp_ch.ready, rsp_ch.valid && rsp_ch.last_pixel, "point line not flagged last")

endmodule

bind line_rasterizer lrast_chk u_lrast_chk (
   .clock  (clock),
   .reset  (reset),
   .req_ch (req_ch),
   .rsp_ch (rsp_ch)
);
